[src/pee_pkg.sv]
// Shared constants, node codes and controller/datapath interface types for the evaluator.
package pee_pkg;

	localparam int DATA_W         = 32;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 2;
	localparam int WORD_COUNT     = 4;
	localparam int CODE_W         = 4;
	localparam int STORE_NODES    = 64;
	localparam int NODE_IDX_W     = $clog2(STORE_NODES);
	localparam int MAX_NODES_DEF  = 64;

	// Node codes. Codes above CODE_MAX read as a leaf of value zero.
	localparam logic [CODE_W-1:0] CODE_X0  = 4'd0;
	localparam logic [CODE_W-1:0] CODE_Y0  = 4'd1;
	localparam logic [CODE_W-1:0] CODE_X1  = 4'd2;
	localparam logic [CODE_W-1:0] CODE_Y1  = 4'd3;
	localparam logic [CODE_W-1:0] CODE_K   = 4'd4;
	localparam logic [CODE_W-1:0] CODE_ADD = 4'd5;
	localparam logic [CODE_W-1:0] CODE_SUB = 4'd6;
	localparam logic [CODE_W-1:0] CODE_MUL = 4'd7;
	localparam logic [CODE_W-1:0] CODE_MIN = 4'd8;
	localparam logic [CODE_W-1:0] CODE_MAX = 4'd9;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture operands and empty the stack
		logic push;      // push the current operator node
		logic leaf;      // load the current leaf value into the accumulator
		logic set_left;  // park the accumulator as left operand of the top entry
		logic combine;   // apply the top operator to its left operand and the accumulator
		logic finish;    // register the result
		logic bad;       // the finished tree is malformed
	} pee_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_op;
		logic empty;
		logic full;
		logic top_has_left;
	} pee_stat_t;

endpackage

[src/pee_ctrl.sv]
// Sequencer that walks the prefix program one node per cycle, pausing after each leaf to fold finished subtrees.
module pee_ctrl #(
	parameter int MAX_NODES = pee_pkg::MAX_NODES_DEF,
	parameter int POS_W     = $clog2(MAX_NODES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  pee_pkg::pee_stat_t stat,
	output pee_pkg::pee_cmd_t  cmd,
	output logic [POS_W-1:0]   node_pos
);
	import pee_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_FETCH  = 2'd1;
	localparam logic [1:0] S_REDUCE = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pos_d   = pos_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					pos_d    = '0;
					state_d  = S_FETCH;
				end
			end
			S_FETCH: begin
				if (pos_q == POS_W'(MAX_NODES)) begin
					// The tree needs a node past the end of the store.
					cmd.finish = 1'b1;
					cmd.bad    = 1'b1;
					state_d    = S_IDLE;
				end else if (stat.is_op) begin
					if (stat.full) begin
						// Too many open operators to ever complete in the store.
						cmd.finish = 1'b1;
						cmd.bad    = 1'b1;
						state_d    = S_IDLE;
					end else begin
						cmd.push = 1'b1;
						pos_d    = pos_q + POS_W'(1);
					end
				end else begin
					cmd.leaf = 1'b1;
					pos_d    = pos_q + POS_W'(1);
					state_d  = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (stat.empty) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else if (stat.top_has_left) begin
					cmd.combine = 1'b1;
				end else begin
					cmd.set_left = 1'b1;
					state_d      = S_FETCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign node_pos = pos_q;

endmodule

[src/pee_datapath.sv]
// Program store, operand registers, operator stack and ALU of the evaluator.
module pee_datapath #(
	parameter int MAX_NODES = pee_pkg::MAX_NODES_DEF,
	parameter int POS_W     = $clog2(MAX_NODES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pee_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pee_pkg::CFG_W-1:0]         cfg_data,
	input  logic [pee_pkg::DATA_W-1:0]        x_first,
	input  logic [pee_pkg::DATA_W-1:0]        x_second,
	input  logic [pee_pkg::DATA_W-1:0]        y_first,
	input  logic [pee_pkg::DATA_W-1:0]        y_second,
	input  logic [pee_pkg::DATA_W-1:0]        constant_value,
	input  pee_pkg::pee_cmd_t                 cmd,
	input  logic [POS_W-1:0]                  node_pos,
	output pee_pkg::pee_stat_t                stat,
	output logic [pee_pkg::DATA_W-1:0]        result_value,
	output logic                              malformed
);
	import pee_pkg::*;

	// A complete tree in MAX_NODES nodes never has more than MAX_NODES/2 open operators.
	localparam int STACK_DEPTH = (MAX_NODES / 2 > 2) ? MAX_NODES / 2 : 2;
	localparam int SIDX_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	logic [CFG_W-1:0]            prog_q [WORD_COUNT];
	logic [DATA_W-1:0]           x0_q, x1_q, y0_q, y1_q, k_q;
	logic [DATA_W-1:0]           acc_q;
	logic [DATA_W-1:0]           result_q;
	logic                        malformed_q;
	logic [SP_W-1:0]             sp_q;
	logic [CODE_W-1:0]           op_q   [STACK_DEPTH];
	logic [DATA_W-1:0]           left_q [STACK_DEPTH];
	logic                        hl_q   [STACK_DEPTH];

	logic [WORD_COUNT*CFG_W-1:0] prog_flat;
	logic [NODE_IDX_W-1:0]       node_idx;
	logic [CODE_W-1:0]           code;
	logic [DATA_W-1:0]           leaf_val;
	logic [SIDX_W-1:0]           top_idx;
	logic [SIDX_W-1:0]           push_idx;
	logic [CODE_W-1:0]           top_op;
	logic [DATA_W-1:0]           opa, opb, alu;
	logic [DATA_W-1:0]           prod;

	always_comb begin
		for (int w = 0; w < WORD_COUNT; w++) begin
			prog_flat[w*CFG_W +: CFG_W] = prog_q[w];
		end
	end

	assign node_idx = NODE_IDX_W'(node_pos);
	assign code     = prog_flat[{node_idx, 2'b00} +: CODE_W];

	always_comb begin
		case (code)
			CODE_X0: leaf_val = x0_q;
			CODE_Y0: leaf_val = y0_q;
			CODE_X1: leaf_val = x1_q;
			CODE_Y1: leaf_val = y1_q;
			CODE_K:  leaf_val = k_q;
			default: leaf_val = '0;
		endcase
	end

	assign top_idx  = SIDX_W'(sp_q - SP_W'(1));
	assign push_idx = SIDX_W'(sp_q);
	assign top_op   = op_q[top_idx];
	assign opa      = left_q[top_idx];
	assign opb      = acc_q;
	assign prod     = opa * opb;

	always_comb begin
		case (top_op)
			CODE_ADD: alu = opa + opb;
			CODE_SUB: alu = opa - opb;
			CODE_MUL: alu = prod;
			CODE_MIN: alu = ($signed(opa) <= $signed(opb)) ? opa : opb;
			CODE_MAX: alu = ($signed(opa) >= $signed(opb)) ? opa : opb;
			default:  alu = opb;
		endcase
	end

	assign stat.is_op        = (code inside {[CODE_ADD:CODE_MAX]});
	assign stat.empty        = (sp_q == '0);
	assign stat.full         = (sp_q == SP_W'(STACK_DEPTH));
	assign stat.top_has_left = hl_q[top_idx];

	// Program words, the stack pointer and the malformed flag carry reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORD_COUNT; w++) begin
				prog_q[w] <= '0;
			end
			sp_q        <= '0;
			malformed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				prog_q[cfg_index] <= cfg_data;
			end
			if (cmd.load) begin
				sp_q <= '0;
			end else if (cmd.push) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (cmd.combine) begin
				sp_q <= sp_q - SP_W'(1);
			end
			if (cmd.finish) begin
				malformed_q <= cmd.bad;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= x_first;
			x1_q <= x_second;
			y0_q <= y_first;
			y1_q <= y_second;
			k_q  <= constant_value;
		end
		if (cmd.leaf) begin
			acc_q <= leaf_val;
		end else if (cmd.combine) begin
			acc_q <= alu;
		end
		if (cmd.push) begin
			op_q[push_idx] <= code;
			hl_q[push_idx] <= 1'b0;
		end else if (cmd.set_left) begin
			left_q[top_idx] <= acc_q;
			hl_q[top_idx]   <= 1'b1;
		end
		if (cmd.finish) begin
			result_q <= cmd.bad ? '0 : acc_q;
		end
	end

	assign result_value = result_q;
	assign malformed    = malformed_q;

endmodule

[src/prefix_expression_evaluator.sv]
// Top level of the prefix expression evaluator: controller plus datapath.
// The sequencer reads one node per cycle while fetching; after each leaf it stops to reduce, and
// for each operator it first parks the left operand and later folds it with the right one on the ALU.
// One item is in work at a time; busy goes high once the start beat is registered and is low
// again in the result strobe cycle, which can already take the next start. The receiver cannot
// stall. Reset clears the program.
module prefix_expression_evaluator #(
	parameter int MAX_NODES = pee_pkg::MAX_NODES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pee_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pee_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [pee_pkg::DATA_W-1:0]    x_first,
	input  logic signed [pee_pkg::DATA_W-1:0]    x_second,
	input  logic signed [pee_pkg::DATA_W-1:0]    y_first,
	input  logic signed [pee_pkg::DATA_W-1:0]    y_second,
	input  logic signed [pee_pkg::DATA_W-1:0]    constant_value,
	output logic                                 done,
	output logic signed [pee_pkg::DATA_W-1:0]    result_value,
	output logic                                 malformed
);
	import pee_pkg::*;

	localparam int POS_W = $clog2(MAX_NODES + 1);

	// The controller owns the node position and the state; the datapath owns the program,
	// the operand registers, the operator stack and the result registers. A result beat is
	// the single cycle in which done is high, with result_value and malformed alongside.
	pee_cmd_t         cmd;
	pee_stat_t        stat;
	logic [POS_W-1:0] node_pos;
	logic [DATA_W-1:0] result_raw;

	pee_ctrl #(
		.MAX_NODES (MAX_NODES),
		.POS_W     (POS_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.done     (done),
		.stat     (stat),
		.cmd      (cmd),
		.node_pos (node_pos)
	);

	pee_datapath #(
		.MAX_NODES (MAX_NODES),
		.POS_W     (POS_W)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.x_first        (x_first),
		.x_second       (x_second),
		.y_first        (y_first),
		.y_second       (y_second),
		.constant_value (constant_value),
		.cmd            (cmd),
		.node_pos       (node_pos),
		.stat           (stat),
		.result_value   (result_raw),
		.malformed      (malformed)
	);

	// Two's complement wraparound is kept end to end; the port only reinterprets the bits.
	assign result_value = $signed(result_raw);

endmodule
